// File: rtl/core/bbc_pkg.sv
// Package for the bracket balance checker: stack codes, symbol constants, symbol decoder.
package bbc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 64;

    localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;
    localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;
    localparam logic [7:0] CH_BRACE_OPEN   = 8'h7B;
    localparam logic [7:0] CH_BRACE_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;
    localparam logic [7:0] CH_BAR          = 8'h7C;

    typedef enum logic [2:0] {
        CODE_PAREN  = 3'd0,
        CODE_BRACE  = 3'd1,
        CODE_SQUARE = 3'd2,
        CODE_ANGLE  = 3'd3,
        CODE_BAR    = 3'd4
    } code_t;

    typedef enum logic [1:0] {
        SYM_OTHER = 2'd0,
        SYM_OPEN  = 2'd1,
        SYM_CLOSE = 2'd2,
        SYM_TOGGLE = 2'd3
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t kind;
        code_t     code;
    } sym_t;

    function automatic sym_t decode_symbol(input logic [7:0] ch);
        sym_t s;
        s.kind = SYM_OTHER;
        s.code = CODE_PAREN;
        case (ch)
            CH_PAREN_OPEN:   begin s.kind = SYM_OPEN;   s.code = CODE_PAREN;  end
            CH_BRACE_OPEN:   begin s.kind = SYM_OPEN;   s.code = CODE_BRACE;  end
            CH_SQUARE_OPEN:  begin s.kind = SYM_OPEN;   s.code = CODE_SQUARE; end
            CH_ANGLE_OPEN:   begin s.kind = SYM_OPEN;   s.code = CODE_ANGLE;  end
            CH_PAREN_CLOSE:  begin s.kind = SYM_CLOSE;  s.code = CODE_PAREN;  end
            CH_BRACE_CLOSE:  begin s.kind = SYM_CLOSE;  s.code = CODE_BRACE;  end
            CH_SQUARE_CLOSE: begin s.kind = SYM_CLOSE;  s.code = CODE_SQUARE; end
            CH_ANGLE_CLOSE:  begin s.kind = SYM_CLOSE;  s.code = CODE_ANGLE;  end
            CH_BAR:          begin s.kind = SYM_TOGGLE; s.code = CODE_BAR;    end
            default:         begin s.kind = SYM_OTHER;  s.code = CODE_PAREN;  end
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bracket_balance_checker.sv
// Top level of the bracket balance checker: stack control, verdict and output register.
//
// One character per beat on the s_axis side, tlast on the final character of a string.
// Beats may follow back to back while s_axis_tready is high; one verdict beat
// per string comes out of an output register in the cycle after its last character.
// The top of the stack lives in a register; the entry below it is read from the stack
// RAM in the cycle before it is needed, with a bypass when that entry was written in the cycle before.
// The input stalls only while a verdict waits and the master side holds tready low.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // last_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] balanced, [1] overflowed, [7:2] zero
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(STACK_DEPTH);

    logic [FW-1:0]       fill_reg, fill_next;
    bbc_pkg::code_t      top_reg, top_next;
    logic                mismatch_reg, mismatch_next;
    logic                overflow_reg, overflow_next;
    logic                fwd_valid_reg;
    bbc_pkg::code_t      fwd_data_reg;
    logic                out_valid_reg;
    logic                balanced_reg, overflowed_reg;

    logic                accept;
    bbc_pkg::sym_t       sym;
    bbc_pkg::code_t      below_top;
    logic [2:0]          rd_data;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic                fin_mismatch, fin_overflow;
    logic [FW-1:0]       fin_fill;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sym           = bbc_pkg::decode_symbol(s_axis_tdata);
    assign below_top     = fwd_valid_reg ? fwd_data_reg : bbc_pkg::code_t'(rd_data);

    always_comb
    begin
        fin_fill     = fill_reg;
        fin_mismatch = mismatch_reg;
        fin_overflow = overflow_reg;
        top_next     = top_reg;
        we           = 1'b0;
        waddr        = AW'(fill_reg - FW'(1));
        if (accept && !mismatch_reg)
        begin
            case (sym.kind)
                bbc_pkg::SYM_OPEN, bbc_pkg::SYM_TOGGLE:
                begin
                    if (sym.kind == bbc_pkg::SYM_TOGGLE && fill_reg != '0
                        && top_reg == bbc_pkg::CODE_BAR)
                    begin
                        fin_fill = fill_reg - FW'(1);
                        top_next = below_top;
                    end
                    else if (fill_reg == FULL)
                    begin
                        fin_overflow = 1'b1;
                    end
                    else
                    begin
                        we       = (fill_reg != '0) && !s_axis_tlast;
                        fin_fill = fill_reg + FW'(1);
                        top_next = sym.code;
                    end
                end
                bbc_pkg::SYM_CLOSE:
                begin
                    if (fill_reg != '0 && top_reg == sym.code)
                    begin
                        fin_fill = fill_reg - FW'(1);
                        top_next = below_top;
                    end
                    else
                    begin
                        fin_mismatch = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        fill_next     = fin_fill;
        mismatch_next = fin_mismatch;
        overflow_next = fin_overflow;
        if (accept && s_axis_tlast)
        begin
            fill_next     = '0;
            mismatch_next = 1'b0;
            overflow_next = 1'b0;
        end
        raddr = (fill_next >= FW'(2)) ? AW'(fill_next - FW'(2)) : '0;
    end

    bbc_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (top_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            mismatch_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            mismatch_reg  <= mismatch_next;
            overflow_reg  <= overflow_next;
            fwd_valid_reg <= we && (waddr == raddr);
            if (accept && s_axis_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
        if (accept && s_axis_tlast)
        begin
            balanced_reg   <= !fin_mismatch && !fin_overflow && (fin_fill == '0);
            overflowed_reg <= fin_overflow;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, overflowed_reg, balanced_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("stack fill beyond depth");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (fill_reg == '0 && !mismatch_reg && !overflow_reg))
        else $error("state not cleared after last beat");

    a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(balanced_reg && overflowed_reg))
        else $error("balanced verdict with overflow");

    a_fwd_depth: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> (fill_reg >= FW'(2)))
        else $error("bypass active with fewer than two entries");

endmodule
